// File: rtl/idq_pkg.sv
// shared constants and types for the inverse depth quantizer
package idq_pkg;

    // fixed field widths
    localparam int DEPTH_W         = 24;
    localparam int CODE_BITS       = 16;
    localparam int DEPTH_FRAC_BITS = 16;
    localparam int QA_W            = 24;
    localparam int QB_W            = 25;
    localparam int LIMIT_W         = 24;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] REG_QUANT_A     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_B     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT = 2'd2;

    localparam logic [QA_W-1:0]    QUANT_A_RST     = 24'd10100;
    localparam logic [QB_W-1:0]    QUANT_B_RST     = -25'sd1009;
    localparam logic [LIMIT_W-1:0] DEPTH_LIMIT_RST = 24'd655360;

    // operation modes
    localparam logic MODE_QUANT   = 1'b0;
    localparam logic MODE_DEQUANT = 1'b1;

    // divider geometry: code - B always fits the width of B as unsigned
    localparam int DIV_W         = QB_W;
    localparam int DVD_W         = QA_W + DEPTH_FRAC_BITS;
    // quotient bits kept; anything at or above 2^Q_BITS saturates in both modes
    localparam int Q_BITS        = 2 * ((DIV_W + 2) / 2);
    localparam int HI_W          = DVD_W - Q_BITS;
    localparam int BITS_PER_STEP = 2;
    localparam int STEPS         = Q_BITS / BITS_PER_STEP;

    localparam logic [CODE_BITS-1:0] CODE_MAX  = {CODE_BITS{1'b1}};
    localparam logic [DEPTH_W-1:0]   DEPTH_SAT = {DEPTH_W{1'b1}};

    typedef struct packed {
        logic mode;
        logic active;   // division result is used
        logic ovf;      // quotient at or above 2^Q_BITS
    } idq_ctl_t;

endpackage

// File: rtl/idq_div_step.sv
// one pipelined restoring division stage, two quotient bits per stage
module idq_div_step (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  idq_pkg::idq_ctl_t             ctl_in,
    input  logic [idq_pkg::DIV_W-1:0]     div_in,
    input  logic [idq_pkg::DIV_W-1:0]     rem_in,
    input  logic [idq_pkg::Q_BITS-1:0]    sh_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output idq_pkg::idq_ctl_t             ctl_out,
    output logic [idq_pkg::DIV_W-1:0]     div_out,
    output logic [idq_pkg::DIV_W-1:0]     rem_out,
    output logic [idq_pkg::Q_BITS-1:0]    sh_out
);
    import idq_pkg::*;

    logic                valid_reg;
    idq_ctl_t            ctl_reg;
    logic [DIV_W-1:0]    div_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [Q_BITS-1:0]   sh_reg;
    logic [DIV_W-1:0]    rem_next;
    logic [Q_BITS-1:0]   sh_next;

    assign in_ready = !valid_reg || out_ready;

    // sh holds the remaining dividend bits on top, quotient bits shift in below
    always_comb begin
        logic [DIV_W-1:0]  r;
        logic [Q_BITS-1:0] s;
        logic [DIV_W:0]    t;
        logic              qb;
        r = rem_in;
        s = sh_in;
        for (int i = 0; i < BITS_PER_STEP; i++) begin
            t  = {r, s[Q_BITS-1]};
            qb = (t >= {1'b0, div_in});
            if (qb) begin
                t = t - {1'b0, div_in};
            end
            r = t[DIV_W-1:0];
            s = {s[Q_BITS-2:0], qb};
        end
        rem_next = r;
        sh_next  = s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctl_reg <= ctl_in;
            div_reg <= div_in;
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
        end
    end

    assign out_valid = valid_reg;
    assign ctl_out   = ctl_reg;
    assign div_out   = div_reg;
    assign rem_out   = rem_reg;
    assign sh_out    = sh_reg;

endmodule

// File: rtl/inverse_depth_quantizer.sv
// inverse depth quantizer top level: decode, pipelined divider, saturation
//
//  channel | ports                                   | transfer when
//  --------+-----------------------------------------+----------------------
//  input   | s_valid s_ready s_mode s_depth_in ...   | s_valid && s_ready
//  result  | m_valid m_ready m_code_out ...          | m_valid && m_ready
//  config  | cfg_valid cfg_ready cfg_index cfg_data  | cfg_valid && cfg_ready
//
// one pixel per cycle while m_ready allows; stages: decode, range check,
// 13 divider stages of two quotient bits each, saturation register.
// every stage has its own valid bit and moves when the next one is free,
// so bubbles close up and a stall on m_ready backs up stage by stage.
// synchronous active-low reset empties the pipeline and restores the
// register defaults; cfg_ready is always high.
module inverse_depth_quantizer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [idq_pkg::DEPTH_W-1:0]       s_depth_in,
    input  logic                              s_depth_in_valid,
    input  logic [idq_pkg::CODE_BITS-1:0]     s_code_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [idq_pkg::CODE_BITS-1:0]     m_code_out,
    output logic [idq_pkg::DEPTH_W-1:0]       m_depth_out,
    output logic                              m_depth_out_valid,
    output logic                              m_clipped,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [idq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [idq_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import idq_pkg::*;

    // configuration registers
    logic [QA_W-1:0]    quant_a_reg;
    logic [QB_W-1:0]    quant_b_reg;
    logic [LIMIT_W-1:0] depth_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quant_a_reg     <= QUANT_A_RST;
            quant_b_reg     <= QUANT_B_RST;
            depth_limit_reg <= DEPTH_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_QUANT_A:     quant_a_reg     <= cfg_data[QA_W-1:0];
                REG_QUANT_B:     quant_b_reg     <= cfg_data[QB_W-1:0];
                REG_DEPTH_LIMIT: depth_limit_reg <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage a: pick divisor and decide whether the division counts
    logic             a_valid_reg;
    idq_ctl_t         a_ctl_reg;
    logic [DIV_W-1:0] a_div_reg;
    idq_ctl_t         a_ctl_next;
    logic [DIV_W-1:0] a_div_next;
    logic [DIV_W:0]   code_diff;
    logic             a_ready;

    logic             b_valid_reg;
    idq_ctl_t         b_ctl_reg;
    logic [DIV_W-1:0] b_div_reg;
    logic [DIV_W-1:0] b_rem_reg;
    logic [Q_BITS-1:0] b_sh_reg;
    logic             b_ready;

    logic              st_valid [0:STEPS];
    logic              st_ready [0:STEPS];
    idq_ctl_t          st_ctl   [0:STEPS];
    logic [DIV_W-1:0]  st_div   [0:STEPS];
    logic [DIV_W-1:0]  st_rem   [0:STEPS];
    logic [Q_BITS-1:0] st_sh    [0:STEPS];

    assign s_ready = a_ready;
    assign a_ready = !a_valid_reg || b_ready;

    // code - B, one bit wider so the sign shows
    assign code_diff = {{(DIV_W + 1 - CODE_BITS){1'b0}}, s_code_in}
                     - {quant_b_reg[QB_W-1], quant_b_reg};

    always_comb begin
        a_ctl_next.mode = s_mode;
        a_ctl_next.ovf  = 1'b0;
        if (s_mode == MODE_QUANT) begin
            a_ctl_next.active = s_depth_in_valid && (s_depth_in != '0)
                              && (s_depth_in < depth_limit_reg);
            a_div_next = {{(DIV_W - DEPTH_W){1'b0}}, s_depth_in};
        end else begin
            a_ctl_next.active = (s_code_in != '0) && !code_diff[DIV_W]
                              && (code_diff != '0);
            a_div_next = code_diff[DIV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && s_valid) begin
            a_ctl_reg <= a_ctl_next;
            a_div_reg <= a_div_next;
        end
    end

    // stage b: top dividend bits against divisor, seed the divider
    logic [DVD_W-1:0] dividend;
    logic [HI_W-1:0]  dvd_hi;
    logic             ovf_next;
    idq_ctl_t         b_ctl_next;

    assign dividend = {quant_a_reg, {DEPTH_FRAC_BITS{1'b0}}};
    assign dvd_hi   = dividend[DVD_W-1:Q_BITS];
    assign ovf_next = {{(DIV_W - HI_W){1'b0}}, dvd_hi} >= a_div_reg;

    always_comb begin
        b_ctl_next     = a_ctl_reg;
        b_ctl_next.ovf = ovf_next;
    end

    assign b_ready = !b_valid_reg || st_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    // on overflow the remainder seed is zeroed, the quotient is ignored anyway
    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_ctl_reg <= b_ctl_next;
            b_div_reg <= a_div_reg;
            b_rem_reg <= ovf_next ? '0 : {{(DIV_W - HI_W){1'b0}}, dvd_hi};
            b_sh_reg  <= dividend[Q_BITS-1:0];
        end
    end

    assign st_valid[0] = b_valid_reg;
    assign st_ctl[0]   = b_ctl_reg;
    assign st_div[0]   = b_div_reg;
    assign st_rem[0]   = b_rem_reg;
    assign st_sh[0]    = b_sh_reg;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        idq_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[k]),
            .in_ready  (st_ready[k]),
            .ctl_in    (st_ctl[k]),
            .div_in    (st_div[k]),
            .rem_in    (st_rem[k]),
            .sh_in     (st_sh[k]),
            .out_valid (st_valid[k+1]),
            .out_ready (st_ready[k+1]),
            .ctl_out   (st_ctl[k+1]),
            .div_out   (st_div[k+1]),
            .rem_out   (st_rem[k+1]),
            .sh_out    (st_sh[k+1])
        );
    end

    // output stage: add offset in quantize mode, saturate
    logic                 o_valid_reg;
    logic [CODE_BITS-1:0] o_code_reg;
    logic [DEPTH_W-1:0]   o_depth_reg;
    logic                 o_dvalid_reg;
    logic                 o_clip_reg;
    logic [CODE_BITS-1:0] o_code_next;
    logic [DEPTH_W-1:0]   o_depth_next;
    logic                 o_dvalid_next;
    logic                 o_clip_next;
    logic [Q_BITS+1:0]    code_sum;
    logic [Q_BITS-1:0]    quo;
    idq_ctl_t             f_ctl;

    // two spare bits: quotient plus a positive offset can pass 2^Q_BITS
    assign quo      = st_sh[STEPS];
    assign f_ctl    = st_ctl[STEPS];
    assign code_sum = {2'b00, quo}
                    + {{(Q_BITS + 2 - QB_W){quant_b_reg[QB_W-1]}}, quant_b_reg};

    always_comb begin
        o_code_next   = '0;
        o_depth_next  = '0;
        o_dvalid_next = 1'b0;
        o_clip_next   = 1'b0;
        if (f_ctl.active) begin
            if (f_ctl.mode == MODE_QUANT) begin
                if (f_ctl.ovf) begin
                    o_code_next = CODE_MAX;
                    o_clip_next = 1'b1;
                end else if (code_sum[Q_BITS+1]) begin
                    o_clip_next = 1'b1;
                end else if (code_sum[Q_BITS:CODE_BITS] != '0) begin
                    o_code_next = CODE_MAX;
                    o_clip_next = 1'b1;
                end else begin
                    o_code_next = code_sum[CODE_BITS-1:0];
                end
            end else begin
                o_dvalid_next = 1'b1;
                if (f_ctl.ovf || (quo[Q_BITS-1:DEPTH_W] != '0)) begin
                    o_depth_next = DEPTH_SAT;
                    o_clip_next  = 1'b1;
                end else begin
                    o_depth_next = quo[DEPTH_W-1:0];
                end
            end
        end
    end

    assign st_ready[STEPS] = !o_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (st_ready[STEPS]) begin
            o_valid_reg <= st_valid[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_ready[STEPS] && st_valid[STEPS]) begin
            o_code_reg   <= o_code_next;
            o_depth_reg  <= o_depth_next;
            o_dvalid_reg <= o_dvalid_next;
            o_clip_reg   <= o_clip_next;
        end
    end

    assign m_valid           = o_valid_reg;
    assign m_code_out        = o_code_reg;
    assign m_depth_out       = o_depth_reg;
    assign m_depth_out_valid = o_dvalid_reg;
    assign m_clipped         = o_clip_reg;

endmodule
